### design/tfpd_pkg.sv
// tfpd_pkg: shared types and constants for the tilt filter / PID motor drive core.
// Holds the configuration struct, the controller-to-datapath command and status
// structs, and the fixed-point constants. No dependencies.
package tfpd_pkg;

  // configuration register indexes
  localparam logic [2:0] REG_PROP_GAIN     = 3'd0;
  localparam logic [2:0] REG_INTEG_GAIN    = 3'd1;
  localparam logic [2:0] REG_DERIV_GAIN    = 3'd2;
  localparam logic [2:0] REG_BALANCE_ANGLE = 3'd3;
  localparam logic [2:0] REG_BLEND_WEIGHT  = 3'd4;
  localparam logic [2:0] REG_DEAD_BAND     = 3'd5;
  localparam logic [2:0] REG_DUTY_FLOOR    = 3'd6;
  localparam logic [2:0] REG_DUTY_CEILING  = 3'd7;

  // configuration reset values
  localparam logic signed [23:0] PROP_GAIN_RST     = -24'sd89600;
  localparam logic signed [23:0] INTEG_GAIN_RST    = -24'sd14080;
  localparam logic signed [23:0] DERIV_GAIN_RST    = -24'sd10240;
  localparam logic signed [16:0] BALANCE_ANGLE_RST = -17'sd77;
  localparam logic [16:0]        BLEND_WEIGHT_RST  = 17'd62259;
  localparam logic [15:0]        DEAD_BAND_RST     = 16'd256;
  localparam logic [11:0]        DUTY_FLOOR_RST    = 12'd130;
  localparam logic [11:0]        DUTY_CEILING_RST  = 12'd1023;

  // fixed-point constants
  localparam logic signed [23:0] TICK_SCALE  = 24'sd100000;   // 1 s / 10 us
  localparam logic [16:0]        Q16_ONE     = 17'd65536;
  localparam logic [63:0]        ROUND_HALF  = 64'd3276800000; // half of 65536 * 100000
  localparam logic [47:0]        TILT_SAT_Y  = 48'd4608000000; // 46080 * 100000
  localparam logic [47:0]        DUTY_SAT_Y  = 48'd409600000;  // 4096 * 100000
  localparam logic [15:0]        TILT_LIMIT  = 16'd46080;
  localparam logic [12:0]        DUTY_SAT_Q  = 13'd4096;
  localparam logic [12:0]        DUTY_OFFSET = 13'd300;
  localparam logic signed [40:0] INTEG_MAX   = 41'sd549755813887;
  localparam logic [18:0]        DIV_D1      = 19'd100000;
  localparam logic [18:0]        DIV_D2      = 19'd200000;
  localparam logic [18:0]        DIV_D3      = 19'd300000;
  localparam logic [2:0]         DIV_LAST    = 3'd7;          // eight radix-4 steps

  typedef struct packed {
    logic signed [23:0] prop_gain;
    logic signed [23:0] integ_gain;
    logic signed [23:0] deriv_gain;
    logic signed [16:0] balance_angle;
    logic [16:0]        blend_weight;
    logic [15:0]        dead_band;
    logic [11:0]        duty_floor;
    logic [11:0]        duty_ceiling;
  } cfg_t;

  // operand pair for the shared multiplier
  typedef enum logic [3:0] {
    MUL_OLD_SCALE,
    MUL_RATE_TICKS,
    MUL_ACCEL_CW,
    MUL_PRED_W,
    MUL_ACC_SCALE,
    MUL_ERR_TICKS,
    MUL_ERR_KP,
    MUL_RATE_KD,
    MUL_INTEG_KI
  } mul_sel_t;

  typedef enum logic [1:0] {
    ACC_HOLD,
    ACC_LOAD,
    ACC_ADD
  } acc_op_t;

  typedef struct packed {
    logic     load_in;
    mul_sel_t mul_sel;
    acc_op_t  acc_op;
    logic     div_init_tilt;
    logic     div_init_duty;
    logic     div_step;
    logic     tilt_commit;
    logic     integ_update;
    logic     load_out;
  } dp_cmd_t;

  typedef struct packed {
    logic dband;
  } dp_stat_t;

endpackage

### design/tfpd_cfg.sv
// tfpd_cfg: configuration register file, written through a plain write port.
// Depends on tfpd_pkg (cfg_t, register indexes, reset values).
module tfpd_cfg (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_wr_en,
  input  logic [2:0]          cfg_index,
  input  logic [23:0]         cfg_data,
  output tfpd_pkg::cfg_t      cfg
);

  tfpd_pkg::cfg_t regs;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.prop_gain     <= tfpd_pkg::PROP_GAIN_RST;
      regs.integ_gain    <= tfpd_pkg::INTEG_GAIN_RST;
      regs.deriv_gain    <= tfpd_pkg::DERIV_GAIN_RST;
      regs.balance_angle <= tfpd_pkg::BALANCE_ANGLE_RST;
      regs.blend_weight  <= tfpd_pkg::BLEND_WEIGHT_RST;
      regs.dead_band     <= tfpd_pkg::DEAD_BAND_RST;
      regs.duty_floor    <= tfpd_pkg::DUTY_FLOOR_RST;
      regs.duty_ceiling  <= tfpd_pkg::DUTY_CEILING_RST;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        tfpd_pkg::REG_PROP_GAIN:     regs.prop_gain     <= cfg_data;
        tfpd_pkg::REG_INTEG_GAIN:    regs.integ_gain    <= cfg_data;
        tfpd_pkg::REG_DERIV_GAIN:    regs.deriv_gain    <= cfg_data;
        tfpd_pkg::REG_BALANCE_ANGLE: regs.balance_angle <= cfg_data[16:0];
        tfpd_pkg::REG_BLEND_WEIGHT:  regs.blend_weight  <= cfg_data[16:0];
        tfpd_pkg::REG_DEAD_BAND:     regs.dead_band     <= cfg_data[15:0];
        tfpd_pkg::REG_DUTY_FLOOR:    regs.duty_floor    <= cfg_data[11:0];
        tfpd_pkg::REG_DUTY_CEILING:  regs.duty_ceiling  <= cfg_data[11:0];
        default: ;
      endcase
    end
  end

  assign cfg = regs;

endmodule

### design/tfpd_dp.sv
// tfpd_dp: datapath with one shared 46x24 multiplier, a 64-bit accumulator,
// a radix-4 divider by 100000, filter/integral state and the result register.
// Depends on tfpd_pkg (cfg_t, dp_cmd_t, dp_stat_t, constants).
module tfpd_dp (
  input  logic                 clk,
  input  logic                 rst,
  input  tfpd_pkg::dp_cmd_t    cmd,
  output tfpd_pkg::dp_stat_t   stat,
  input  tfpd_pkg::cfg_t       cfg,
  input  logic signed [19:0]   rate_sample,
  input  logic signed [16:0]   accel_tilt,
  input  logic [15:0]          elapsed_ticks,
  output logic                 drive_on,
  output logic                 go_forward,
  output logic [12:0]          duty_value,
  output logic signed [16:0]   tilt_estimate
);

  // latched sample
  logic signed [19:0] rate_q;
  logic signed [16:0] accel_q;
  logic [15:0]        ticks_q;

  // persistent state
  logic signed [16:0] tilt_angle;
  logic               primed;
  logic signed [39:0] integ;

  // per-item working registers
  logic signed [17:0] err;
  logic               dband;
  logic signed [63:0] prod;
  logic signed [63:0] acc;
  logic [16:0]        div_rem;
  logic [15:0]        div_low;
  logic [15:0]        div_q;
  logic               div_sat;
  logic               tilt_neg;
  logic               set_pos;

  logic [16:0]        w_eff;
  logic [16:0]        w_cmp;
  logic signed [16:0] old;
  logic signed [45:0] mul_a;
  logic signed [23:0] mul_b;
  logic signed [69:0] mul_p;

  logic [63:0]        acc_mag;
  logic [63:0]        round_sum;
  logic [47:0]        y_tilt;
  logic [47:0]        y_duty;

  logic [18:0]        div_t;
  logic [1:0]         digit;
  logic [18:0]        div_diff;

  logic [15:0]        tilt_mag;
  logic signed [16:0] tilt_new;
  logic signed [17:0] err_new;
  logic [17:0]        err_mag;
  logic               dband_now;

  logic signed [40:0] integ_sum;
  logic signed [39:0] integ_new;

  logic [12:0]        duty_q;
  logic [12:0]        duty_hi;
  logic [12:0]        duty_clamped;

  // blend weight above one counts as one
  assign w_eff = (cfg.blend_weight > tfpd_pkg::Q16_ONE) ? tfpd_pkg::Q16_ONE : cfg.blend_weight;
  assign w_cmp = tfpd_pkg::Q16_ONE - w_eff;
  assign old   = primed ? tilt_angle : accel_q;

  always_comb begin
    case (cmd.mul_sel)
      tfpd_pkg::MUL_OLD_SCALE: begin
        mul_a = {{29{old[16]}}, old};
        mul_b = tfpd_pkg::TICK_SCALE;
      end
      tfpd_pkg::MUL_RATE_TICKS: begin
        mul_a = {{26{rate_q[19]}}, rate_q};
        mul_b = {8'd0, ticks_q};
      end
      tfpd_pkg::MUL_ACCEL_CW: begin
        mul_a = {{29{accel_q[16]}}, accel_q};
        mul_b = {7'd0, w_cmp};
      end
      tfpd_pkg::MUL_PRED_W: begin
        mul_a = acc[45:0];
        mul_b = {7'd0, w_eff};
      end
      tfpd_pkg::MUL_ACC_SCALE: begin
        mul_a = acc[45:0];
        mul_b = tfpd_pkg::TICK_SCALE;
      end
      tfpd_pkg::MUL_ERR_TICKS: begin
        mul_a = {{28{err[17]}}, err};
        mul_b = {8'd0, ticks_q};
      end
      tfpd_pkg::MUL_ERR_KP: begin
        mul_a = {{28{err[17]}}, err};
        mul_b = cfg.prop_gain;
      end
      tfpd_pkg::MUL_RATE_KD: begin
        mul_a = {{26{rate_q[19]}}, rate_q};
        mul_b = cfg.deriv_gain;
      end
      tfpd_pkg::MUL_INTEG_KI: begin
        mul_a = {{6{integ[39]}}, integ};
        mul_b = cfg.integ_gain;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  // magnitude and the two quotient inputs
  assign acc_mag   = acc[63] ? (64'd0 - acc) : acc;
  assign round_sum = acc_mag + tfpd_pkg::ROUND_HALF;
  assign y_tilt    = round_sum[63:16];
  assign y_duty    = acc_mag[63:16];

  // radix-4 restoring step against 100000
  assign div_t = {div_rem, div_low[15:14]};
  always_comb begin
    if (div_t >= tfpd_pkg::DIV_D3) begin
      digit    = 2'd3;
      div_diff = div_t - tfpd_pkg::DIV_D3;
    end else if (div_t >= tfpd_pkg::DIV_D2) begin
      digit    = 2'd2;
      div_diff = div_t - tfpd_pkg::DIV_D2;
    end else if (div_t >= tfpd_pkg::DIV_D1) begin
      digit    = 2'd1;
      div_diff = div_t - tfpd_pkg::DIV_D1;
    end else begin
      digit    = 2'd0;
      div_diff = div_t;
    end
  end

  // new estimate and error
  assign tilt_mag = div_sat ? tfpd_pkg::TILT_LIMIT : div_q;
  assign tilt_new = tilt_neg ? (17'sd0 - $signed({1'b0, tilt_mag})) : $signed({1'b0, tilt_mag});
  assign err_new  = {tilt_new[16], tilt_new} - {cfg.balance_angle[16], cfg.balance_angle};

  assign err_mag   = err[17] ? (18'd0 - err) : err;
  assign dband_now = err_mag < {2'd0, cfg.dead_band};
  assign stat.dband = dband_now;

  // integral with saturation; prod holds err * ticks here
  assign integ_sum = {integ[39], integ} + prod[40:0];
  always_comb begin
    if (integ_sum > tfpd_pkg::INTEG_MAX) begin
      integ_new = tfpd_pkg::INTEG_MAX[39:0];
    end else if (integ_sum < -tfpd_pkg::INTEG_MAX) begin
      integ_new = 40'sd0 - tfpd_pkg::INTEG_MAX[39:0];
    end else begin
      integ_new = integ_sum[39:0];
    end
  end

  // duty: ceiling first, floor wins
  assign duty_q       = div_sat ? tfpd_pkg::DUTY_SAT_Q : {1'b0, div_q[11:0]};
  assign duty_hi      = (duty_q > {1'b0, cfg.duty_ceiling}) ? {1'b0, cfg.duty_ceiling} : duty_q;
  assign duty_clamped = (duty_hi < {1'b0, cfg.duty_floor}) ? {1'b0, cfg.duty_floor} : duty_hi;

  always_ff @(posedge clk) begin
    if (rst) begin
      tilt_angle <= '0;
      primed     <= 1'b0;
      integ      <= '0;
    end else begin
      if (cmd.tilt_commit) begin
        tilt_angle <= tilt_new;
        primed     <= 1'b1;
      end
      if (cmd.integ_update) begin
        integ <= dband_now ? 40'sd0 : integ_new;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      rate_q  <= rate_sample;
      accel_q <= accel_tilt;
      ticks_q <= elapsed_ticks;
    end

    prod <= mul_p[63:0];

    case (cmd.acc_op)
      tfpd_pkg::ACC_LOAD: acc <= prod;
      tfpd_pkg::ACC_ADD:  acc <= acc + prod;
      default: ;
    endcase

    if (cmd.div_init_tilt) begin
      div_sat  <= y_tilt >= tfpd_pkg::TILT_SAT_Y;
      div_rem  <= y_tilt[32:16];
      div_low  <= y_tilt[15:0];
      div_q    <= '0;
      tilt_neg <= acc[63];
    end else if (cmd.div_init_duty) begin
      div_sat  <= y_duty >= tfpd_pkg::DUTY_SAT_Y;
      div_rem  <= y_duty[32:16];
      div_low  <= y_duty[15:0];
      div_q    <= '0;
      set_pos  <= !acc[63] && (acc != 64'sd0);
    end else if (cmd.div_step) begin
      div_rem <= div_diff[16:0];
      div_low <= {div_low[13:0], 2'd0};
      div_q   <= {div_q[13:0], digit};
    end

    if (cmd.tilt_commit) begin
      err <= err_new;
    end
    if (cmd.integ_update) begin
      dband <= dband_now;
    end

    if (cmd.load_out) begin
      drive_on      <= !dband;
      go_forward    <= !dband && set_pos;
      duty_value    <= dband ? 13'd0 : (duty_clamped + tfpd_pkg::DUTY_OFFSET);
      tilt_estimate <= tilt_angle;
    end
  end

endmodule

### design/tfpd_ctrl.sv
// tfpd_ctrl: sequencer for one sample: filter products, rounding divide,
// integral update, PID products, duty divide, result hand-off.
// Depends on tfpd_pkg (dp_cmd_t, dp_stat_t, constants).
module tfpd_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  output tfpd_pkg::dp_cmd_t   cmd,
  input  tfpd_pkg::dp_stat_t  stat
);

  typedef enum logic [19:0] {
    ST_IDLE  = 20'h00001,
    ST_M1    = 20'h00002,
    ST_M2    = 20'h00004,
    ST_M3    = 20'h00008,
    ST_M4    = 20'h00010,
    ST_M5    = 20'h00020,
    ST_M6    = 20'h00040,
    ST_RND   = 20'h00080,
    ST_DIV_T = 20'h00100,
    ST_TILT  = 20'h00200,
    ST_P1    = 20'h00400,
    ST_P2    = 20'h00800,
    ST_P3    = 20'h01000,
    ST_P4    = 20'h02000,
    ST_P5    = 20'h04000,
    ST_P6    = 20'h08000,
    ST_P7    = 20'h10000,
    ST_MAG   = 20'h20000,
    ST_DIV_D = 20'h40000,
    ST_OUT   = 20'h80000
  } state_t;

  state_t     state, state_next;
  logic [2:0] div_cnt, div_cnt_next;
  logic       out_valid_next;

  assign in_ready = (state == ST_IDLE);

  always_comb begin
    state_next   = state;
    div_cnt_next = div_cnt;
    cmd          = '0;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_next  = ST_M1;
        end
      end
      ST_M1: begin
        cmd.mul_sel = tfpd_pkg::MUL_OLD_SCALE;
        state_next  = ST_M2;
      end
      ST_M2: begin
        cmd.mul_sel = tfpd_pkg::MUL_RATE_TICKS;
        cmd.acc_op  = tfpd_pkg::ACC_LOAD;
        state_next  = ST_M3;
      end
      ST_M3: begin
        cmd.mul_sel = tfpd_pkg::MUL_ACCEL_CW;
        cmd.acc_op  = tfpd_pkg::ACC_ADD;
        state_next  = ST_M4;
      end
      ST_M4: begin
        cmd.mul_sel = tfpd_pkg::MUL_PRED_W;
        cmd.acc_op  = tfpd_pkg::ACC_LOAD;
        state_next  = ST_M5;
      end
      ST_M5: begin
        cmd.mul_sel = tfpd_pkg::MUL_ACC_SCALE;
        cmd.acc_op  = tfpd_pkg::ACC_LOAD;
        state_next  = ST_M6;
      end
      ST_M6: begin
        cmd.acc_op = tfpd_pkg::ACC_ADD;
        state_next = ST_RND;
      end
      ST_RND: begin
        cmd.div_init_tilt = 1'b1;
        div_cnt_next      = '0;
        state_next        = ST_DIV_T;
      end
      ST_DIV_T: begin
        cmd.div_step = 1'b1;
        div_cnt_next = div_cnt + 3'd1;
        if (div_cnt == tfpd_pkg::DIV_LAST) begin
          state_next = ST_TILT;
        end
      end
      ST_TILT: begin
        cmd.tilt_commit = 1'b1;
        state_next      = ST_P1;
      end
      ST_P1: begin
        cmd.mul_sel = tfpd_pkg::MUL_ERR_TICKS;
        state_next  = ST_P2;
      end
      ST_P2: begin
        cmd.mul_sel      = tfpd_pkg::MUL_ERR_KP;
        cmd.integ_update = 1'b1;
        state_next       = stat.dband ? ST_OUT : ST_P3;
      end
      ST_P3: begin
        cmd.mul_sel = tfpd_pkg::MUL_RATE_KD;
        cmd.acc_op  = tfpd_pkg::ACC_LOAD;
        state_next  = ST_P4;
      end
      ST_P4: begin
        cmd.acc_op = tfpd_pkg::ACC_ADD;
        state_next = ST_P5;
      end
      ST_P5: begin
        cmd.mul_sel = tfpd_pkg::MUL_ACC_SCALE;
        state_next  = ST_P6;
      end
      ST_P6: begin
        cmd.mul_sel = tfpd_pkg::MUL_INTEG_KI;
        cmd.acc_op  = tfpd_pkg::ACC_LOAD;
        state_next  = ST_P7;
      end
      ST_P7: begin
        cmd.acc_op = tfpd_pkg::ACC_ADD;
        state_next = ST_MAG;
      end
      ST_MAG: begin
        cmd.div_init_duty = 1'b1;
        div_cnt_next      = '0;
        state_next        = ST_DIV_D;
      end
      ST_DIV_D: begin
        cmd.div_step = 1'b1;
        div_cnt_next = div_cnt + 3'd1;
        if (div_cnt == tfpd_pkg::DIV_LAST) begin
          state_next = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!out_valid || out_ready) begin
          cmd.load_out = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_next = out_valid;
    if (cmd.load_out) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      div_cnt   <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      div_cnt   <= div_cnt_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

### design/tilt_filter_pid_motor_drive_core.sv
// Tilt filter + PID motor drive core. One sample is processed at a time; inside the deadband
// the PID products and the duty divide are skipped. The next sample is taken the cycle after
// the result is loaded. The sequence is set by the single shared multiplier and two 8-step
// radix-4 divides by 100000.
// Reset (rst, synchronous): config registers to defaults, tilt and integral to zero,
// first-sample flag cleared, no result pending.
module tilt_filter_pid_motor_drive_core (
  input  logic               clk,
  input  logic               rst,
  // configuration write port
  input  logic               cfg_wr_en,
  input  logic [2:0]         cfg_index,
  input  logic [23:0]        cfg_data,
  // sample channel
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [19:0] rate_sample,
  input  logic signed [16:0] accel_tilt,
  input  logic [15:0]        elapsed_ticks,
  // result channel
  output logic               out_valid,
  input  logic               out_ready,
  output logic               drive_on,
  output logic               go_forward,
  output logic [12:0]        duty_value,
  output logic signed [16:0] tilt_estimate
);

  // Flow for one beat:
  //  - filter: pred = old*1e5 + rate*ticks, num = w*pred + (1-w)*accel*1e5, built
  //    in the accumulator from one product per cycle;
  //  - round |num| / (65536*1e5) to nearest: add half, drop 16 bits, then divide by
  //    1e5 two quotient bits per cycle; saturates at 46080;
  //  - error, saturated integral (cleared in the deadband);
  //  - setpoint S = (kp*err + kd*rate)*1e5 + ki*integral, truncated the same way and
  //    clamped to the duty ceiling and floor; skipped in the deadband.
  // The result register holds a finished beat while the next sample is taken.

  tfpd_pkg::cfg_t     cfg;
  tfpd_pkg::dp_cmd_t  cmd;
  tfpd_pkg::dp_stat_t stat;

  tfpd_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  tfpd_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .stat      (stat)
  );

  tfpd_dp u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .stat          (stat),
    .cfg           (cfg),
    .rate_sample   (rate_sample),
    .accel_tilt    (accel_tilt),
    .elapsed_ticks (elapsed_ticks),
    .drive_on      (drive_on),
    .go_forward    (go_forward),
    .duty_value    (duty_value),
    .tilt_estimate (tilt_estimate)
  );

endmodule

### design/tfpd_checker.sv
// tfpd_checker: port-level assertions for the tilt filter / PID motor drive core,
// bound to the top level. Depends on the top level's ports only.
module tfpd_checker (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic               drive_on,
  input logic               go_forward,
  input logic [12:0]        duty_value,
  input logic signed [16:0] tilt_estimate
);

  // one sample at a time: busy right after a beat is taken
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("in_ready high right after a sample beat");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(duty_value) && $stable(drive_on)
                                   && $stable(tilt_estimate)))
    else $error("stalled result changed");

  a_stop_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !drive_on) |-> (duty_value == 13'd0 && !go_forward))
    else $error("stopped result with nonzero duty or forward");

  a_duty_range: assert property (@(posedge clk) disable iff (rst)
    (out_valid && drive_on) |-> (duty_value >= 13'd300 && duty_value <= 13'd4395))
    else $error("duty outside offset range");

  a_tilt_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (tilt_estimate <= 17'sd46080 && tilt_estimate >= -17'sd46080))
    else $error("tilt estimate beyond saturation");

endmodule

bind tilt_filter_pid_motor_drive_core tfpd_checker u_tfpd_checker (
  .clk           (clk),
  .rst           (rst),
  .in_valid      (in_valid),
  .in_ready      (in_ready),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .drive_on      (drive_on),
  .go_forward    (go_forward),
  .duty_value    (duty_value),
  .tilt_estimate (tilt_estimate)
);

### test/drive_result_checker.sv
// drive_result_checker: watches the config port and both handshakes of the tilt
// filter / PID drive core, predicts every result and compares it field by field.
// Depends on tfpd_pkg for register indexes and reset values.
module drive_result_checker (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_wr_en,
  input  logic [2:0]         cfg_index,
  input  logic [23:0]        cfg_data,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic signed [19:0] rate_sample,
  input  logic signed [16:0] accel_tilt,
  input  logic [15:0]        elapsed_ticks,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic               drive_on,
  input  logic               go_forward,
  input  logic [12:0]        duty_value,
  input  logic signed [16:0] tilt_estimate,
  output int                 fail_count,
  output int                 pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint unsigned FULL_DIV  = 64'd6553600000;  // 65536 * 100000
  localparam longint unsigned HALF_DIV  = 64'd3276800000;
  localparam longint          SCALE_1E5 = 100000;
  localparam longint          BLEND_MAX = 65536;
  localparam longint          TILT_SAT  = 46080;
  localparam longint          INTEG_SAT = 64'sd549755813887;  // 2^39 - 1

  typedef struct packed {
    logic               drive_on;
    logic               go_forward;
    logic [12:0]        duty;
    logic signed [16:0] tilt;
  } drive_t;

  // shadow of the config registers
  logic signed [23:0] kp, ki, kd;
  logic signed [16:0] bal;
  logic [16:0]        blend;
  logic [15:0]        band;
  logic [11:0]        dfloor, dceil;

  longint tilt_est;
  longint integ;
  bit     primed;
  int     result_beats;
  drive_t awaited_drive[$];

  function automatic longint unsigned abs_u(longint v);
    return (v < 0) ? longint'(-v) : v;
  endfunction

  // one sample in, one drive result out; advances the filter and integral state
  function automatic drive_t predict_drive(logic signed [19:0] rate_in,
                                           logic signed [16:0] accel_in,
                                           logic [15:0] ticks_in);
    longint rate, accel, ticks, w, prev, pred, num, err, sp;
    longint unsigned q;
    drive_t res;
    rate  = rate_in;
    accel = accel_in;
    ticks = ticks_in;
    w = blend;
    if (w > BLEND_MAX) w = BLEND_MAX;
    prev = primed ? tilt_est : accel;
    primed = 1'b1;

    pred = prev * SCALE_1E5 + rate * ticks;
    num  = w * pred + (BLEND_MAX - w) * accel * SCALE_1E5;
    q = (abs_u(num) + HALF_DIV) / FULL_DIV;
    if (q > TILT_SAT) q = TILT_SAT;
    tilt_est = (num < 0) ? -longint'(q) : longint'(q);

    err = tilt_est - longint'(bal);
    integ = integ + err * ticks;
    if (integ > INTEG_SAT) integ = INTEG_SAT;
    if (integ < -INTEG_SAT) integ = -INTEG_SAT;
    res.tilt = tilt_est[16:0];

    if (abs_u(err) < band) begin
      integ = 0;
      res.drive_on   = 1'b0;
      res.go_forward = 1'b0;
      res.duty       = '0;
    end else begin
      sp = (longint'(kp) * err + longint'(kd) * rate) * SCALE_1E5 + longint'(ki) * integ;
      q = abs_u(sp) / FULL_DIV;
      if (q > dceil) q = dceil;
      if (q < dfloor) q = dfloor;
      res.drive_on   = 1'b1;
      res.go_forward = (sp > 0);
      res.duty       = 13'(q + 300);
    end
    return res;
  endfunction

  task automatic report_mismatch(string msg);
    fail_count++;
    $display("%0t ns result beat %0d: %s", $time, result_beats, msg);
  endtask

  always @(posedge clk) begin
    drive_t want;
    if (rst) begin
      kp = tfpd_pkg::PROP_GAIN_RST;
      ki = tfpd_pkg::INTEG_GAIN_RST;
      kd = tfpd_pkg::DERIV_GAIN_RST;
      bal = tfpd_pkg::BALANCE_ANGLE_RST;
      blend = tfpd_pkg::BLEND_WEIGHT_RST;
      band = tfpd_pkg::DEAD_BAND_RST;
      dfloor = tfpd_pkg::DUTY_FLOOR_RST;
      dceil = tfpd_pkg::DUTY_CEILING_RST;
      tilt_est = 0;
      integ = 0;
      primed = 1'b0;
      result_beats = 0;
      fail_count = 0;
      awaited_drive.delete();
    end else begin
      // result side first: a result leaving now belongs to an older sample
      if (out_valid && out_ready) begin
        if (awaited_drive.size() == 0) begin
          report_mismatch($sformatf("unexpected result, tilt %0d duty %0d",
                                    tilt_estimate, duty_value));
        end else begin
          want = awaited_drive.pop_front();
          if (drive_on !== want.drive_on)
            report_mismatch($sformatf("drive_on %b, want %b", drive_on, want.drive_on));
          if (go_forward !== want.go_forward)
            report_mismatch($sformatf("go_forward %b, want %b", go_forward, want.go_forward));
          if (duty_value !== want.duty)
            report_mismatch($sformatf("duty_value %0d, want %0d", duty_value, want.duty));
          if (tilt_estimate !== want.tilt)
            report_mismatch($sformatf("tilt_estimate %0d, want %0d", tilt_estimate, want.tilt));
        end
        result_beats++;
      end
      if (in_valid && in_ready)
        awaited_drive.push_back(predict_drive(rate_sample, accel_tilt, elapsed_ticks));
      if (cfg_wr_en) begin
        case (cfg_index)
          tfpd_pkg::REG_PROP_GAIN:     kp = cfg_data;
          tfpd_pkg::REG_INTEG_GAIN:    ki = cfg_data;
          tfpd_pkg::REG_DERIV_GAIN:    kd = cfg_data;
          tfpd_pkg::REG_BALANCE_ANGLE: bal = cfg_data[16:0];
          tfpd_pkg::REG_BLEND_WEIGHT:  blend = cfg_data[16:0];
          tfpd_pkg::REG_DEAD_BAND:     band = cfg_data[15:0];
          tfpd_pkg::REG_DUTY_FLOOR:    dfloor = cfg_data[11:0];
          tfpd_pkg::REG_DUTY_CEILING:  dceil = cfg_data[11:0];
          default: ;
        endcase
      end
    end
    pending = awaited_drive.size();
  end

endmodule

### test/testbench.sv
// testbench: drives samples and config into tilt_filter_pid_motor_drive_core and
// gives the verdict; prediction and comparison live in drive_result_checker.
// Depends on tfpd_pkg, the core and the checker.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NUM_REGS      = 8;
  localparam int PHASES        = 8;
  localparam int PHASE_ITEMS   = 235;
  localparam int HOLD_PHASE    = 4;     // runs with no sender idling
  localparam int HOLD_AT_ITEM  = 60;
  localparam int HOLD_CYCLES   = 300;
  localparam int GAP_CAP       = 24;
  localparam int SETTLE_CYCLES = 40;    // settle time after the last awaited result
  localparam int STALL_LIMIT   = 3000;

  logic               clk = 1'b0;
  logic               rst;
  logic               cfg_wr_en;
  logic [2:0]         cfg_index;
  logic [23:0]        cfg_data;
  logic               in_valid;
  logic               in_ready;
  logic signed [19:0] rate_sample;
  logic signed [16:0] accel_tilt;
  logic [15:0]        elapsed_ticks;
  logic               out_valid;
  logic               out_ready;
  logic               drive_on;
  logic               go_forward;
  logic [12:0]        duty_value;
  logic signed [16:0] tilt_estimate;
  int                 fail_count;
  int                 pending;

  int  tx_idle_pct  = 0;
  int  rx_stall_pct = 0;
  bit  hold_off_req = 1'b0;
  int  quiet_cycles = 0;
  logic [23:0] setting [NUM_REGS];

  tilt_filter_pid_motor_drive_core dut (.*);
  drive_result_checker check (.*);

  // 12 ns period
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // One sample beat. Random idle cycles come first (valid low), then valid is
  // raised at a falling edge and held until the rising edge that takes it.
  task automatic send_sample(input logic signed [19:0] r, input logic signed [16:0] a,
                             input logic [15:0] t);
    int gap;
    gap = 0;
    while (gap < GAP_CAP && $urandom_range(99) < tx_idle_pct) gap++;
    repeat (gap) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid      <= 1'b1;
    rate_sample   <= r;
    accel_tilt    <= a;
    elapsed_ticks <= t;
    do @(posedge clk); while (!in_ready);
  endtask

  // Drop valid, wait for every awaited result, then let the core settle so a
  // config write can never land on a sample in flight.
  task automatic quiesce();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Write all eight registers back to back, one per cycle.
  task automatic load_setting();
    for (int i = 0; i < NUM_REGS; i++) begin
      @(negedge clk);
      cfg_wr_en <= 1'b1;
      cfg_index <= 3'(i);
      cfg_data  <= setting[i];
    end
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic default_setting();
    setting[tfpd_pkg::REG_PROP_GAIN]     = 24'(tfpd_pkg::PROP_GAIN_RST);
    setting[tfpd_pkg::REG_INTEG_GAIN]    = 24'(tfpd_pkg::INTEG_GAIN_RST);
    setting[tfpd_pkg::REG_DERIV_GAIN]    = 24'(tfpd_pkg::DERIV_GAIN_RST);
    setting[tfpd_pkg::REG_BALANCE_ANGLE] = 24'(tfpd_pkg::BALANCE_ANGLE_RST);
    setting[tfpd_pkg::REG_BLEND_WEIGHT]  = 24'(tfpd_pkg::BLEND_WEIGHT_RST);
    setting[tfpd_pkg::REG_DEAD_BAND]     = 24'(tfpd_pkg::DEAD_BAND_RST);
    setting[tfpd_pkg::REG_DUTY_FLOOR]    = 24'(tfpd_pkg::DUTY_FLOOR_RST);
    setting[tfpd_pkg::REG_DUTY_CEILING]  = 24'(tfpd_pkg::DUTY_CEILING_RST);
  endtask

  // Result side. Random stalls per cycle; a hold-off request from the stimulus
  // keeps ready low for a long stretch so the core backs up into in_ready.
  initial begin
    bit hold_taken;
    hold_taken = 1'b0;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off_req && !hold_taken) begin
        hold_taken = 1'b1;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end else begin
        out_ready <= ($urandom_range(99) >= rx_stall_pct);
      end
    end
  end

  // Watchdog: ends the run if no beat moves on either channel for too long.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("tilt_filter_pid_motor_drive_core: mismatch");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    logic signed [19:0] rate;
    logic signed [16:0] accel;
    logic [15:0]        ticks;
    int                 sway;

    rst           = 1'b1;
    cfg_wr_en     = 1'b0;
    cfg_index     = '0;
    cfg_data      = '0;
    in_valid      = 1'b0;
    rate_sample   = '0;
    accel_tilt    = '0;
    elapsed_ticks = '0;
    sway          = 0;

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // --- directed, reset defaults ---
    // first sample: the old estimate comes from this beat's accel tilt
    send_sample(20'sd0, 17'sd1000, 16'd100);
    // gyro and tick extremes drive the estimate into both saturation limits
    send_sample(20'sh7FFFF, 17'sd46080, 16'hFFFF);
    send_sample(20'sh80000, -17'sd46080, 16'hFFFF);
    send_sample(20'sd0, 17'sd0, 16'd0);
    send_sample(-20'sd1, -17'sd1, 16'd1);
    // accel bits beyond the nominal tilt range, both signs
    send_sample(20'sd0, 17'sh0FFFF, 16'd500);
    send_sample(20'sd0, 17'sh10000, 16'd500);
    send_sample(20'sd1200, -17'sd77, 16'd200);
    quiesce();

    // --- directed, gyro weight zero and no integral term ---
    // With zero blend weight the estimate equals accel exactly, so err is set
    // directly: balance -77, dead band 256.
    default_setting();
    setting[tfpd_pkg::REG_INTEG_GAIN]   = '0;
    setting[tfpd_pkg::REG_BLEND_WEIGHT] = '0;
    load_setting();
    send_sample(-20'sd2240, 17'sd179, 16'd100);   // err 256: P and D cancel, zero setpoint
    send_sample(20'sd0, 17'sd178, 16'd10);        // err 255: just inside the dead band
    send_sample(20'sd0, -17'sd333, 16'd10);       // err -256: just outside, mid duty
    send_sample(20'sd0, 17'sd46080, 16'hFFFF);    // large err: ceiling
    send_sample(-20'sd2200, 17'sd183, 16'd5);     // tiny setpoint: floor
    send_sample(20'sd0, 17'sd223, 16'd1);
    send_sample(20'sh7FFFF, -17'sd46080, 16'd0);  // rate term dominates
    send_sample(20'sd0, -17'sd77, 16'd0);         // err zero
    quiesce();

    // --- random phases, one register setting and one idling mode each ---
    for (int phase = 0; phase < PHASES; phase++) begin
      case (phase)
        0: default_setting();
        1: begin
          // top extremes; balance at the top keeps err one-signed so the
          // integral climbs to its limit
          setting[tfpd_pkg::REG_PROP_GAIN]     = 24'h7FFFFF;
          setting[tfpd_pkg::REG_INTEG_GAIN]    = 24'h7FFFFF;
          setting[tfpd_pkg::REG_DERIV_GAIN]    = 24'h7FFFFF;
          setting[tfpd_pkg::REG_BALANCE_ANGLE] = 24'(46080);
          setting[tfpd_pkg::REG_BLEND_WEIGHT]  = 24'(65536);
          setting[tfpd_pkg::REG_DEAD_BAND]     = '0;
          setting[tfpd_pkg::REG_DUTY_FLOOR]    = '0;
          setting[tfpd_pkg::REG_DUTY_CEILING]  = 24'(4095);
        end
        2: begin
          // bottom extremes; floor above ceiling
          setting[tfpd_pkg::REG_PROP_GAIN]     = 24'h800000;
          setting[tfpd_pkg::REG_INTEG_GAIN]    = 24'h800000;
          setting[tfpd_pkg::REG_DERIV_GAIN]    = 24'h800000;
          setting[tfpd_pkg::REG_BALANCE_ANGLE] = 24'(-46080);
          setting[tfpd_pkg::REG_BLEND_WEIGHT]  = '0;
          setting[tfpd_pkg::REG_DEAD_BAND]     = 24'(65535);
          setting[tfpd_pkg::REG_DUTY_FLOOR]    = 24'(4095);
          setting[tfpd_pkg::REG_DUTY_CEILING]  = '0;
        end
        3: begin
          // gyro weight above one is treated as one
          default_setting();
          setting[tfpd_pkg::REG_BALANCE_ANGLE] = '0;
          setting[tfpd_pkg::REG_BLEND_WEIGHT]  = 24'h01FFFF;
          setting[tfpd_pkg::REG_DEAD_BAND]     = '0;
          setting[tfpd_pkg::REG_DUTY_FLOOR]    = 24'(300);
          setting[tfpd_pkg::REG_DUTY_CEILING]  = 24'(2000);
        end
        default: begin
          setting[tfpd_pkg::REG_PROP_GAIN]     = 24'(int'($urandom_range(524288)) - 262144);
          setting[tfpd_pkg::REG_INTEG_GAIN]    = 24'(int'($urandom_range(131072)) - 65536);
          setting[tfpd_pkg::REG_DERIV_GAIN]    = 24'(int'($urandom_range(65536)) - 32768);
          setting[tfpd_pkg::REG_BALANCE_ANGLE] = 24'(int'($urandom_range(8000)) - 4000);
          setting[tfpd_pkg::REG_BLEND_WEIGHT]  =
            $urandom_range(1) ? 24'($urandom_range(65536, 55000))
                              : 24'($urandom_range(131071));
          setting[tfpd_pkg::REG_DEAD_BAND]     = 24'($urandom_range(1500));
          setting[tfpd_pkg::REG_DUTY_FLOOR]    = 24'($urandom_range(700));
          setting[tfpd_pkg::REG_DUTY_CEILING]  = 24'($urandom_range(4095));
        end
      endcase
      load_setting();

      case (phase % 4)
        0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
        1: begin tx_idle_pct = 72; rx_stall_pct = 0;  end
        2: begin tx_idle_pct = 0;  rx_stall_pct = 72; end
        default: begin tx_idle_pct = 35; rx_stall_pct = 35; end
      endcase

      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (phase == HOLD_PHASE && n == HOLD_AT_ITEM) hold_off_req = 1'b1;
        if ($urandom_range(99) < 15) begin
          // raw noise: every bit pattern of every field
          rate  = 20'($urandom());
          accel = 17'($urandom());
          ticks = 16'($urandom());
        end else begin
          // a plausible wobble: accel follows a slow random walk, moderate
          // gyro rates, sample spacing of up to 30 ms
          sway = sway + int'($urandom_range(1200)) - 600;
          if (sway > 12000) sway = 12000;
          if (sway < -12000) sway = -12000;
          accel = 17'(sway + int'($urandom_range(600)) - 300);
          rate  = 20'(int'($urandom_range(40000)) - 20000);
          ticks = 16'($urandom_range(3000));
        end
        send_sample(rate, accel, ticks);
      end
      quiesce();
    end

    if (fail_count == 0) begin
      $display("tilt_filter_pid_motor_drive_core: match");
    end else begin
      $display("tilt_filter_pid_motor_drive_core: mismatch");
    end
    $finish;
  end

endmodule

### filelist.f
design/tfpd_pkg.sv
design/tfpd_cfg.sv
design/tfpd_dp.sv
design/tfpd_ctrl.sv
design/tilt_filter_pid_motor_drive_core.sv
design/tfpd_checker.sv
test/drive_result_checker.sv
test/testbench.sv
